[rtl/core/u8sd_pkg.sv]
// u8sd_pkg: shared types and constants for the UTF-8 stream decoder.
// No dependencies; used by utf8_stream_decoder_top.
`timescale 1ns / 1ps
`default_nettype none

package u8sd_pkg;

  localparam int unsigned CpWidth   = 31;
  localparam int unsigned RemWidth  = 3;
  localparam int unsigned FifoDepth = 4;

  // Lead byte class boundaries
  localparam logic [7:0] ASCII_MAX = 8'h7F;
  localparam logic [7:0] LEAD2_LO  = 8'hC0;
  localparam logic [7:0] LEAD2_HI  = 8'hDF;
  localparam logic [7:0] LEAD3_LO  = 8'hE0;
  localparam logic [7:0] LEAD3_HI  = 8'hEF;
  localparam logic [7:0] LEAD4_LO  = 8'hF0;
  localparam logic [7:0] LEAD4_HI  = 8'hF7;
  localparam logic [7:0] LEAD5_LO  = 8'hF8;
  localparam logic [7:0] LEAD5_HI  = 8'hFB;
  localparam logic [7:0] LEAD6_LO  = 8'hFC;
  localparam logic [7:0] LEAD6_HI  = 8'hFD;

  // Continuation bytes still expected after each lead class
  localparam logic [RemWidth-1:0] REM_NONE = 3'd0;
  localparam logic [RemWidth-1:0] REM_ONE  = 3'd1;
  localparam logic [RemWidth-1:0] REM_TWO  = 3'd2;
  localparam logic [RemWidth-1:0] REM_3    = 3'd3;
  localparam logic [RemWidth-1:0] REM_4    = 3'd4;
  localparam logic [RemWidth-1:0] REM_5    = 3'd5;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               truncated;
    logic               end_of_string;
    logic               last_of_run;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/utf8_stream_decoder_top.sv]
// utf8_stream_decoder_top: byte-serial decoder for 1-to-6-byte UTF-8 forms.
// Depends on u8sd_pkg (result type, lead byte constants).
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | input     | in_valid/in_ready  | data_byte[7:0]
//   out     | output    | out_valid/out_ready| code_point[30:0], truncated,
//           |           |                    | end_of_string, last_of_run
//
// One byte per cycle: decode state updates at the input transfer, results go
// into a four-entry result queue in the same edge, and leave one per cycle.
// A zero byte mid-sequence makes two results; in_ready drops while the
// queue holds more than two entries. rst (synchronous, active high) clears
// decode state and empties the queue. An out-side stall backs up into the
// queue, then lowers in_ready.
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [30:0]      code_point,
  output logic             truncated,
  output logic             end_of_string,
  output logic             last_of_run
);

  localparam int unsigned PtrW = $clog2(u8sd_pkg::FifoDepth);
  localparam int unsigned CntW = PtrW + 1;

  // Decode state
  logic [u8sd_pkg::RemWidth-1:0] bytes_remaining, bytes_remaining_next;
  logic [u8sd_pkg::CpWidth-1:0]  partial_value, partial_value_next;

  // Result queue
  u8sd_pkg::result_t queue [u8sd_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;

  logic in_xfer, out_xfer;
  logic [1:0] push_n;
  u8sd_pkg::result_t res0, res1;
  logic [u8sd_pkg::CpWidth-1:0] trunc_cp, cont_cp;
  u8sd_pkg::result_t terminator;

  // Room for the worst case of two results per byte.
  assign in_ready  = (count <= CntW'(u8sd_pkg::FifoDepth - 2));
  assign in_xfer   = in_valid && in_ready;
  assign out_valid = (count != '0);
  assign out_xfer  = out_valid && out_ready;

  assign terminator = '{code_point: '0, truncated: 1'b0, end_of_string: 1'b1,
                        last_of_run: 1'b1};

  // Partial value padded with zero bits for each missing byte
  always_comb begin
    case (bytes_remaining)
      u8sd_pkg::REM_ONE: trunc_cp = {partial_value[24:0], 6'd0};
      u8sd_pkg::REM_TWO: trunc_cp = {partial_value[18:0], 12'd0};
      u8sd_pkg::REM_3:   trunc_cp = {partial_value[12:0], 18'd0};
      u8sd_pkg::REM_4:   trunc_cp = {partial_value[6:0], 24'd0};
      u8sd_pkg::REM_5:   trunc_cp = {partial_value[0], 30'd0};
      default:           trunc_cp = partial_value;
    endcase
  end

  assign cont_cp = {partial_value[24:0], data_byte[5:0]};

  always_comb begin
    bytes_remaining_next = bytes_remaining;
    partial_value_next   = partial_value;
    push_n = 2'd0;
    res0   = terminator;
    res1   = terminator;
    if (data_byte == 8'd0) begin
      // End of string; flush a cut-short sequence first.
      bytes_remaining_next = u8sd_pkg::REM_NONE;
      partial_value_next   = '0;
      if (bytes_remaining != u8sd_pkg::REM_NONE) begin
        res0 = '{code_point: trunc_cp, truncated: 1'b1, end_of_string: 1'b0,
                 last_of_run: 1'b0};
        push_n = 2'd2;
      end else begin
        push_n = 2'd1;
      end
    end else if (bytes_remaining != u8sd_pkg::REM_NONE) begin
      // Any nonzero byte counts as a continuation.
      bytes_remaining_next = bytes_remaining - 3'd1;
      if (bytes_remaining == u8sd_pkg::REM_ONE) begin
        partial_value_next = '0;
        res0 = '{code_point: cont_cp, truncated: 1'b0, end_of_string: 1'b0,
                 last_of_run: 1'b1};
        push_n = 2'd1;
      end else begin
        partial_value_next = cont_cp;
      end
    end else if (data_byte <= u8sd_pkg::ASCII_MAX) begin
      res0 = '{code_point: {24'd0, data_byte[6:0]}, truncated: 1'b0,
               end_of_string: 1'b0, last_of_run: 1'b1};
      push_n = 2'd1;
    end else if (data_byte >= u8sd_pkg::LEAD2_LO && data_byte <= u8sd_pkg::LEAD2_HI) begin
      partial_value_next   = {26'd0, data_byte[4:0]};
      bytes_remaining_next = u8sd_pkg::REM_ONE;
    end else if (data_byte >= u8sd_pkg::LEAD3_LO && data_byte <= u8sd_pkg::LEAD3_HI) begin
      partial_value_next   = {27'd0, data_byte[3:0]};
      bytes_remaining_next = u8sd_pkg::REM_TWO;
    end else if (data_byte >= u8sd_pkg::LEAD4_LO && data_byte <= u8sd_pkg::LEAD4_HI) begin
      partial_value_next   = {28'd0, data_byte[2:0]};
      bytes_remaining_next = u8sd_pkg::REM_3;
    end else if (data_byte >= u8sd_pkg::LEAD5_LO && data_byte <= u8sd_pkg::LEAD5_HI) begin
      partial_value_next   = {29'd0, data_byte[1:0]};
      bytes_remaining_next = u8sd_pkg::REM_4;
    end else if (data_byte >= u8sd_pkg::LEAD6_LO && data_byte <= u8sd_pkg::LEAD6_HI) begin
      partial_value_next   = {30'd0, data_byte[0]};
      bytes_remaining_next = u8sd_pkg::REM_5;
    end
    // Stray continuation, FE and FF as lead: dropped, state kept.
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_remaining <= u8sd_pkg::REM_NONE;
      partial_value   <= '0;
    end else if (in_xfer) begin
      bytes_remaining <= bytes_remaining_next;
      partial_value   <= partial_value_next;
    end
  end

  // Queue payload (no reset needed)
  always_ff @(posedge clk) begin
    if (in_xfer && push_n != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_xfer && push_n == 2'd2) begin
      queue[wr_ptr + PtrW'(1)] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_xfer) begin
        wr_ptr <= wr_ptr + PtrW'(push_n);
      end
      if (out_xfer) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      count <= count + (in_xfer ? CntW'(push_n) : CntW'(0)) - CntW'(out_xfer);
    end
  end

  assign code_point    = queue[rd_ptr].code_point;
  assign truncated     = queue[rd_ptr].truncated;
  assign end_of_string = queue[rd_ptr].end_of_string;
  assign last_of_run   = queue[rd_ptr].last_of_run;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(u8sd_pkg::FifoDepth))
    else $error("result queue overflow");

  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    bytes_remaining <= u8sd_pkg::REM_5)
    else $error("bytes_remaining out of range");

  a_zero_idles: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && data_byte == 8'd0) |=> (bytes_remaining == u8sd_pkg::REM_NONE
                                        && partial_value == '0))
    else $error("zero byte did not return decoder to idle");

  a_eos_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_string) |-> (code_point == '0 && last_of_run && !truncated))
    else $error("malformed terminator result");

  a_trunc_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> (!last_of_run && !end_of_string))
    else $error("truncated result flagged as last");
`endif

endmodule

`default_nettype wire
